// ----- rtl/sgcs_pkg.sv -----
// Package for the signature column similarity block.
// Holds field widths, stream payload layouts, operation codes and sequencer states.
// No dependencies; used by sgcs_divider and signature_column_similarity under rtl/.
package sgcs_pkg;

  // Field widths
  localparam int ROW_W   = 8;
  localparam int COL_W   = 10;
  localparam int VALUE_W = 32;
  localparam int ENTRY_W = 31;
  localparam int RCFG_W  = 9;
  localparam int MATCH_W = 9;
  localparam int UNION_W = 10;
  localparam int FRAC_W  = 16;
  localparam int SIM_W   = 17;

  // Divider: quotient of (match << FRAC_W) / union, one bit per step
  localparam int DIV_W     = MATCH_W + FRAC_W;
  localparam int DIV_CNT_W = $clog2(DIV_W);

  // Reset value of the row count register
  localparam logic [RCFG_W-1:0] ROWS_RESET = 9'd256;

  // Request kind carried on in_tuser
  typedef enum logic {
    OP_LOAD    = 1'b0,
    OP_COMPARE = 1'b1
  } op_t;

  // Input payload, sig_row in the lowest bits
  typedef struct packed {
    logic [3:0]                pad;
    logic signed [VALUE_W-1:0] sig_value;
    logic [COL_W-1:0]          col_b;
    logic [COL_W-1:0]          col_a;
    logic [ROW_W-1:0]          sig_row;
  } in_data_t;

  // Result payload, match_count in the lowest bits
  typedef struct packed {
    logic [3:0]         pad;
    logic [SIM_W-1:0]   similarity;
    logic [UNION_W-1:0] union_count;
    logic [MATCH_W-1:0] match_count;
  } out_data_t;

  // Compare sequencer
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WALK,
    ST_DRAIN,
    ST_DIV_GO,
    ST_DIV_WAIT,
    ST_DONE
  } state_t;

endpackage

// ----- rtl/sgcs_ram.sv -----
// Generic single-write, dual-read RAM with registered read data.
// No dependencies; holds the signature matrix of the similarity block.
module sgcs_ram #(
  parameter int WIDTH  = 31,
  parameter int DEPTH  = 262144,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [WIDTH-1:0]  wr_data,
  input  logic [ADDR_W-1:0] rd_addr_a,
  input  logic [ADDR_W-1:0] rd_addr_b,
  output logic [WIDTH-1:0]  rd_data_a,
  output logic [WIDTH-1:0]  rd_data_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read ports
  always_ff @(posedge clk) begin
    rd_data_a <= mem[rd_addr_a];
    rd_data_b <= mem[rd_addr_b];
  end

endmodule

// ----- rtl/sgcs_divider.sv -----
// Iterative restoring divider: (match << 16) / union, one quotient bit per cycle.
// Depends on sgcs_pkg for widths.
module sgcs_divider (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [sgcs_pkg::MATCH_W-1:0]  match_count,
  input  logic [sgcs_pkg::UNION_W-1:0]  union_count,
  output logic                          done,
  output logic [sgcs_pkg::SIM_W-1:0]    quotient
);

  logic                            busy_r, busy_nxt;
  logic                            done_r, done_nxt;
  logic [sgcs_pkg::DIV_CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [sgcs_pkg::UNION_W-1:0]    rem_r, rem_nxt;
  logic [sgcs_pkg::DIV_W-1:0]      dq_r, dq_nxt;
  logic [sgcs_pkg::UNION_W-1:0]    dvs_r, dvs_nxt;
  logic [sgcs_pkg::UNION_W:0]      trial;
  logic                            ge;

  // One restoring step: shift in the next dividend bit, subtract if it fits
  always_comb begin
    trial    = {rem_r, dq_r[sgcs_pkg::DIV_W-1]};
    ge       = (trial >= {1'b0, dvs_r});
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    dq_nxt   = dq_r;
    dvs_nxt  = dvs_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      rem_nxt  = '0;
      dq_nxt   = {match_count, {sgcs_pkg::FRAC_W{1'b0}}};
      dvs_nxt  = union_count;
    end else if (busy_r) begin
      rem_nxt = ge ? sgcs_pkg::UNION_W'(trial - {1'b0, dvs_r})
                   : trial[sgcs_pkg::UNION_W-1:0];
      dq_nxt  = {dq_r[sgcs_pkg::DIV_W-2:0], ge};
      cnt_nxt = cnt_r + sgcs_pkg::DIV_CNT_W'(1);
      if (cnt_r == sgcs_pkg::DIV_CNT_W'(sgcs_pkg::DIV_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    dq_r  <= dq_nxt;
    dvs_r <= dvs_nxt;
  end

  assign done     = done_r;
  assign quotient = dq_r[sgcs_pkg::SIM_W-1:0];

endmodule

// ----- rtl/signature_column_similarity.sv -----
// Signature column similarity: top level with request sequencer and match counter.
// Depends on sgcs_pkg, sgcs_ram and sgcs_divider.
//
// Usage:
//   Requests arrive on the in_ stream. in_tuser selects the kind: a load writes
//   one signature entry (row, column, value; zero or negative stores as zero),
//   a compare names two columns and returns one result on the out_ stream with
//   the match count, the union count and match/union as unsigned Q1.16.
//   cfg_wr_en/cfg_wr_data set the number of rows compared; write it only while
//   the block is idle. Zero acts as one, values above MAX_ROWS as MAX_ROWS.
// Throughput:
//   Loads are written straight from the request; in_tready stays high while idle,
//   so loads stream back to back. A compare reads one row per cycle through the
//   two read ports of the signature RAM, then runs the bit-serial divider.
//   in_tready is low while a compare is in flight.
// Reset:
//   rst_n clears the control state and sets the row count to 256. The RAM is
//   not cleared; every entry must be loaded before it is compared.
// Stall:
//   The result sits in an output register. Loads keep being accepted while it
//   waits; a following compare finishes its walk and holds until the register
//   frees up.
module signature_column_similarity #(
  parameter int MAX_ROWS = 256,
  parameter int MAX_COLS = 1024
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // Input stream
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [63:0]                   in_tdata,   // sig_row, col_a, col_b, sig_value
  input  logic [0:0]                    in_tuser,   // operation
  // Result stream
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [39:0]                   out_tdata,  // match_count, union_count, similarity
  // Configuration
  input  logic                          cfg_wr_en,
  input  logic [sgcs_pkg::RCFG_W-1:0]   cfg_wr_data // signature_rows
);

  localparam int DEPTH  = MAX_ROWS * MAX_COLS;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int RW     = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;

  sgcs_pkg::in_data_t               in_d;
  sgcs_pkg::out_data_t              out_d;
  sgcs_pkg::state_t                 state_r, state_nxt;

  logic [sgcs_pkg::RCFG_W-1:0]      rows_cfg_r;
  logic [sgcs_pkg::COL_W-1:0]       col_a_r, col_a_nxt, col_b_r, col_b_nxt;
  logic                             col_a_ok_r, col_a_ok_nxt, col_b_ok_r, col_b_ok_nxt;
  logic [RW-1:0]                    row_r, row_nxt, rows_last_r, rows_last_nxt;
  logic                             rd_vld_r, rd_vld_nxt;
  logic [sgcs_pkg::MATCH_W-1:0]     match_r, match_nxt;
  logic [sgcs_pkg::UNION_W-1:0]     uni_r, uni_nxt;
  logic                             out_valid_r, out_valid_nxt;
  logic [sgcs_pkg::MATCH_W-1:0]     out_match_r, out_match_nxt;
  logic [sgcs_pkg::UNION_W-1:0]     out_union_r, out_union_nxt;
  logic [sgcs_pkg::SIM_W-1:0]       out_sim_r, out_sim_nxt;

  logic                             in_accept, is_compare;
  logic                             wr_en;
  logic [ADDR_W-1:0]                wr_addr, rd_addr_a, rd_addr_b;
  logic [sgcs_pkg::ENTRY_W-1:0]     wr_data, rd_a, rd_b, val_a, val_b;
  logic                             same, nz_a, nz_b;
  logic [1:0]                       uni_inc;
  logic                             div_start, div_done;
  logic [sgcs_pkg::SIM_W-1:0]       div_q;
  logic                             out_free;
  int                               rows_int;

  assign in_d       = sgcs_pkg::in_data_t'(in_tdata);
  assign in_tready  = (state_r == sgcs_pkg::ST_IDLE);
  assign in_accept  = in_tvalid && in_tready;
  assign is_compare = (in_tuser == sgcs_pkg::OP_COMPARE);

  // Load: write the entry directly from the request
  always_comb begin
    wr_en   = in_accept && !is_compare
              && (int'(in_d.sig_row) < MAX_ROWS) && (int'(in_d.col_a) < MAX_COLS);
    wr_addr = ADDR_W'(int'(in_d.sig_row) * MAX_COLS + int'(in_d.col_a));
    wr_data = in_d.sig_value[sgcs_pkg::VALUE_W-1] ? '0
              : in_d.sig_value[sgcs_pkg::ENTRY_W-1:0];
  end

  // Compare walk: read one row of both columns per cycle
  assign rd_addr_a = ADDR_W'(int'(row_r) * MAX_COLS + int'(col_a_r));
  assign rd_addr_b = ADDR_W'(int'(row_r) * MAX_COLS + int'(col_b_r));

  sgcs_ram #(
    .WIDTH  (sgcs_pkg::ENTRY_W),
    .DEPTH  (DEPTH),
    .ADDR_W (ADDR_W)
  ) u_store (
    .clk       (clk),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data),
    .rd_addr_a (rd_addr_a),
    .rd_addr_b (rd_addr_b),
    .rd_data_a (rd_a),
    .rd_data_b (rd_b)
  );

  sgcs_divider u_div (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (div_start),
    .match_count (match_r),
    .union_count (uni_r),
    .done        (div_done),
    .quotient    (div_q)
  );

  // Row compare: columns outside the matrix read as zero
  always_comb begin
    val_a   = col_a_ok_r ? rd_a : '0;
    val_b   = col_b_ok_r ? rd_b : '0;
    same    = (val_a == val_b);
    nz_a    = (val_a != '0);
    nz_b    = (val_b != '0);
    uni_inc = same ? 2'd1 : ({1'b0, nz_a} + {1'b0, nz_b});
  end

  // Clamp the configured row count to 1..MAX_ROWS
  always_comb begin
    rows_int = int'(rows_cfg_r);
    if (rows_int == 0) begin
      rows_int = 1;
    end
    if (rows_int > MAX_ROWS) begin
      rows_int = MAX_ROWS;
    end
    rows_last_nxt = RW'(rows_int - 1);
  end

  assign out_free = !out_valid_r || out_tready;

  // Sequencer and accumulation
  always_comb begin
    state_nxt     = state_r;
    col_a_nxt     = col_a_r;
    col_b_nxt     = col_b_r;
    col_a_ok_nxt  = col_a_ok_r;
    col_b_ok_nxt  = col_b_ok_r;
    row_nxt       = row_r;
    rd_vld_nxt    = 1'b0;
    match_nxt     = match_r;
    uni_nxt       = uni_r;
    div_start     = 1'b0;
    out_valid_nxt = out_valid_r && !out_tready;
    out_match_nxt = out_match_r;
    out_union_nxt = out_union_r;
    out_sim_nxt   = out_sim_r;

    // Fold in the row read in the previous cycle
    if (rd_vld_r) begin
      match_nxt = same ? match_r + sgcs_pkg::MATCH_W'(1) : match_r;
      uni_nxt   = uni_r + sgcs_pkg::UNION_W'(uni_inc);
    end

    case (state_r)
      sgcs_pkg::ST_IDLE: begin
        if (in_accept && is_compare) begin
          col_a_ok_nxt = (int'(in_d.col_a) < MAX_COLS);
          col_b_ok_nxt = (int'(in_d.col_b) < MAX_COLS);
          col_a_nxt    = col_a_ok_nxt ? in_d.col_a : '0;
          col_b_nxt    = col_b_ok_nxt ? in_d.col_b : '0;
          row_nxt      = '0;
          match_nxt    = '0;
          uni_nxt      = '0;
          state_nxt    = sgcs_pkg::ST_WALK;
        end
      end
      sgcs_pkg::ST_WALK: begin
        rd_vld_nxt = 1'b1;
        row_nxt    = row_r + RW'(1);
        if (row_r == rows_last_r) begin
          state_nxt = sgcs_pkg::ST_DRAIN;
        end
      end
      sgcs_pkg::ST_DRAIN: begin
        state_nxt = sgcs_pkg::ST_DIV_GO;
      end
      sgcs_pkg::ST_DIV_GO: begin
        div_start = 1'b1;
        state_nxt = sgcs_pkg::ST_DIV_WAIT;
      end
      sgcs_pkg::ST_DIV_WAIT: begin
        if (div_done) begin
          state_nxt = sgcs_pkg::ST_DONE;
        end
      end
      sgcs_pkg::ST_DONE: begin
        // Hold until the output register is free
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_match_nxt = match_r;
          out_union_nxt = uni_r;
          out_sim_nxt   = div_q;
          state_nxt     = sgcs_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = sgcs_pkg::ST_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= sgcs_pkg::ST_IDLE;
      rows_cfg_r  <= sgcs_pkg::ROWS_RESET;
      rd_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      rd_vld_r    <= rd_vld_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) begin
        rows_cfg_r <= cfg_wr_data;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    col_a_r     <= col_a_nxt;
    col_b_r     <= col_b_nxt;
    col_a_ok_r  <= col_a_ok_nxt;
    col_b_ok_r  <= col_b_ok_nxt;
    row_r       <= row_nxt;
    match_r     <= match_nxt;
    uni_r       <= uni_nxt;
    out_match_r <= out_match_nxt;
    out_union_r <= out_union_nxt;
    out_sim_r   <= out_sim_nxt;
    if (state_r == sgcs_pkg::ST_IDLE) begin
      rows_last_r <= rows_last_nxt;
    end
  end

  // Result stream
  always_comb begin
    out_d             = '0;
    out_d.match_count = out_match_r;
    out_d.union_count = out_union_r;
    out_d.similarity  = out_sim_r;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_d;

endmodule

// ----- verif/signature_column_similarity_test.sv -----
// Testbench for signature_column_similarity: streams load and compare requests with random
// gaps and output stalls, scores each compare on a private copy of the signature matrix.
// Depends on sgcs_pkg and the block's RTL; reads nothing at run time.
module signature_column_similarity_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NUM_ROWS      = 256;
  localparam int NUM_COLS      = 1024;
  localparam int SETTLE_CYCLES = 40;
  localparam int DRAIN_CYCLES  = 300;
  localparam int QUIET_LIMIT   = 4000;
  localparam int MAX_REPORTS   = 40;

  typedef struct {
    logic [sgcs_pkg::MATCH_W-1:0] match_count;
    logic [sgcs_pkg::UNION_W-1:0] union_count;
    logic [sgcs_pkg::SIM_W-1:0]   similarity;
  } score_t;

  logic                          clk         = 1'b0;
  logic                          rst_n       = 1'b0;
  logic                          in_tvalid   = 1'b0;
  logic                          in_tready;
  logic [63:0]                   in_tdata    = '0;
  logic [0:0]                    in_tuser    = '0;
  logic                          out_tvalid;
  logic                          out_tready  = 1'b0;
  logic [39:0]                   out_tdata;
  logic                          cfg_wr_en   = 1'b0;
  logic [sgcs_pkg::RCFG_W-1:0]   cfg_wr_data = '0;

  // Private copy of the matrix, keyed by row * NUM_COLS + column
  logic [sgcs_pkg::ENTRY_W-1:0]  sig_mem [int unsigned];
  logic [sgcs_pkg::RCFG_W-1:0]   rows_reg = sgcs_pkg::ROWS_RESET;
  score_t                        pending_scores [$];
  int                            error_count  = 0;
  int                            burst_left   = 0;
  int                            quiet_cycles = 0;
  int                            rx_mode      = 0;
  int                            rx_left      = 0;
  int                            rx_tick      = 0;

  signature_column_similarity u_top (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------- predictor

  function automatic int unsigned entry_key(input logic [sgcs_pkg::ROW_W-1:0] row,
                                            input logic [sgcs_pkg::COL_W-1:0] col);
    return row * NUM_COLS + col;
  endfunction

  function automatic logic [sgcs_pkg::ENTRY_W-1:0] read_entry(
      input logic [sgcs_pkg::ROW_W-1:0] row, input logic [sgcs_pkg::COL_W-1:0] col);
    int unsigned key;
    key = entry_key(row, col);
    return sig_mem.exists(key) ? sig_mem[key] : '0;
  endfunction

  // Clamp the row register: zero acts as one, anything above the matrix as the full height
  function automatic int unsigned active_rows();
    if (rows_reg == 0) return 1;
    if (rows_reg > NUM_ROWS) return NUM_ROWS;
    return int'(rows_reg);
  endfunction

  function automatic score_t score_columns(input logic [sgcs_pkg::COL_W-1:0] col_x,
                                           input logic [sgcs_pkg::COL_W-1:0] col_y);
    int unsigned                   hits;
    int unsigned                   total;
    logic [sgcs_pkg::ENTRY_W-1:0]  x;
    logic [sgcs_pkg::ENTRY_W-1:0]  y;
    score_t                        s;
    hits  = 0;
    total = 0;
    for (int unsigned r = 0; r < active_rows(); r++) begin
      x = read_entry(sgcs_pkg::ROW_W'(r), col_x);
      y = read_entry(sgcs_pkg::ROW_W'(r), col_y);
      if (x == y) begin
        hits++;
        total++;
      end else begin
        if (x != 0) total++;
        if (y != 0) total++;
      end
    end
    s.match_count = sgcs_pkg::MATCH_W'(hits);
    s.union_count = sgcs_pkg::UNION_W'(total);
    s.similarity  = sgcs_pkg::SIM_W'((hits << sgcs_pkg::FRAC_W) / total);
    return s;
  endfunction

  // Four draws in ten from a tiny alphabet so columns agree often; zero, negatives and extremes mixed in
  function automatic logic [sgcs_pkg::VALUE_W-1:0] pick_value();
    case ($urandom_range(0, 9))
      0, 1:       return '0;
      2:          return {1'b1, 31'($urandom)};
      3, 4, 5, 6: return $urandom_range(1, 3);
      7:          return 32'h7FFF_FFFF;
      default:    return {1'b0, 31'($urandom)};
    endcase
  endfunction

  // ---------------------------------------------------------------- checking

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    error_count++;
    if (error_count <= MAX_REPORTS)
      $display("%0t ns: %s mismatch, got %0d, expected %0d", $realtime, what, got, want);
  endtask

  // Compare each accepted result with the oldest pending score
  always @(posedge clk) begin : check_result
    sgcs_pkg::out_data_t got;
    score_t              want;
    if (rst_n && out_tvalid && out_tready) begin
      got = sgcs_pkg::out_data_t'(out_tdata);
      if (pending_scores.size() == 0) begin
        report_mismatch("unrequested result", 1, 0);
      end else begin
        want = pending_scores.pop_front();
        if (got.match_count !== want.match_count)
          report_mismatch("match_count", got.match_count, want.match_count);
        if (got.union_count !== want.union_count)
          report_mismatch("union_count", got.union_count, want.union_count);
        if (got.similarity !== want.similarity)
          report_mismatch("similarity", got.similarity, want.similarity);
      end
    end
  end

  // Stall the result stream: free running, random, periodic or mostly held
  always @(posedge clk) begin
    if (rx_left == 0) begin
      rx_mode = $urandom_range(0, 3);
      rx_left = $urandom_range(32, 200);
    end else begin
      rx_left--;
    end
    rx_tick++;
    case (rx_mode)
      0:       out_tready <= 1'b1;
      1:       out_tready <= ($urandom_range(0, 3) != 0);
      2:       out_tready <= ((rx_tick % 8) < 3);
      default: out_tready <= ($urandom_range(0, 15) == 0);
    endcase
  end

  // End the run when nothing moves for too long
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_wr_en) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == QUIET_LIMIT) begin
      $display("FAILURE");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------- driving

  // Send one request in a burst, idling between bursts; valid stays up inside a burst
  task automatic send_request(input sgcs_pkg::op_t op,
                              input logic [sgcs_pkg::ROW_W-1:0] row,
                              input logic [sgcs_pkg::COL_W-1:0] col_x,
                              input logic [sgcs_pkg::COL_W-1:0] col_y,
                              input logic [sgcs_pkg::VALUE_W-1:0] value);
    sgcs_pkg::in_data_t req;
    req           = '0;
    req.sig_row   = row;
    req.col_a     = col_x;
    req.col_b     = col_y;
    req.sig_value = value;
    if (burst_left == 0) begin
      in_tvalid <= 1'b0;
      repeat (($urandom_range(0, 3) == 0) ? $urandom_range(4, 14) : $urandom_range(1, 3))
        @(posedge clk);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120)
                                               : $urandom_range(1, 12);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= req;
    in_tuser  <= op;
    do @(posedge clk); while (!in_tready);
    burst_left--;
    if (op == sgcs_pkg::OP_LOAD)
      sig_mem[entry_key(row, col_x)] = value[sgcs_pkg::VALUE_W-1] ? '0
                                       : value[sgcs_pkg::ENTRY_W-1:0];
    else
      pending_scores.push_back(score_columns(col_x, col_y));
  endtask

  // Drop valid and close the current burst
  task automatic hold_input();
    in_tvalid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
  endtask

  // Wait for every pending result, then let a trailing load retire
  task automatic wait_idle();
    hold_input();
    while (pending_scores.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_rows(input logic [sgcs_pkg::RCFG_W-1:0] value);
    wait_idle();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    rows_reg = value;
    @(posedge clk);
  endtask

  // Load every row in use of a column that has not been written yet
  task automatic fill_column(input logic [sgcs_pkg::COL_W-1:0] col);
    for (int r = 0; r < active_rows(); r++)
      if (!sig_mem.exists(entry_key(sgcs_pkg::ROW_W'(r), col)))
        send_request(sgcs_pkg::OP_LOAD, sgcs_pkg::ROW_W'(r), col,
                     sgcs_pkg::COL_W'($urandom), pick_value());
  endtask

  // Random loads and compares over a small pool of columns, plus stray loads anywhere
  task automatic run_random_phase(input logic [sgcs_pkg::RCFG_W-1:0] rows_value,
                                  input int pool_size, input int num_requests);
    logic [sgcs_pkg::COL_W-1:0] cols [$];
    logic [sgcs_pkg::COL_W-1:0] ca;
    logic [sgcs_pkg::COL_W-1:0] cb;
    write_rows(rows_value);
    for (int i = 0; i < pool_size; i++)
      cols.push_back(($urandom_range(0, 5) == 0)
                     ? (i[0] ? sgcs_pkg::COL_W'(NUM_COLS - 1) : '0)
                     : sgcs_pkg::COL_W'($urandom));
    for (int n = 0; n < num_requests; n++) begin
      case ($urandom_range(0, 9))
        0, 1, 2: begin
          ca = cols[$urandom_range(0, pool_size - 1)];
          cb = cols[$urandom_range(0, pool_size - 1)];
          fill_column(ca);
          fill_column(cb);
          send_request(sgcs_pkg::OP_COMPARE, sgcs_pkg::ROW_W'($urandom), ca, cb, $urandom);
        end
        3, 4, 5, 6, 7: begin
          send_request(sgcs_pkg::OP_LOAD,
                       sgcs_pkg::ROW_W'($urandom_range(0, active_rows() - 1)),
                       cols[$urandom_range(0, pool_size - 1)],
                       sgcs_pkg::COL_W'($urandom), pick_value());
        end
        default: begin
          send_request(sgcs_pkg::OP_LOAD, sgcs_pkg::ROW_W'($urandom),
                       sgcs_pkg::COL_W'($urandom), sgcs_pkg::COL_W'($urandom),
                       pick_value());
        end
      endcase
    end
  endtask

  // ---------------------------------------------------------------- tests

  // Zero row count, value extremes, both-zero and one-sided mismatches, truncated ratio
  task automatic test_corner_cases();
    write_rows('0);
    send_request(sgcs_pkg::OP_LOAD, 8'd0, 10'd0, 10'd1023, 32'h7FFF_FFFF);
    send_request(sgcs_pkg::OP_LOAD, 8'd0, 10'd1023, 10'd0, 32'h8000_0000);
    send_request(sgcs_pkg::OP_LOAD, 8'd0, 10'd512, 10'd511, 32'hFFFF_FFFF);
    send_request(sgcs_pkg::OP_LOAD, 8'd0, 10'd1, 10'd1023, 32'h0000_0000);
    send_request(sgcs_pkg::OP_LOAD, 8'd0, 10'd2, 10'd0, 32'h0000_0001);
    send_request(sgcs_pkg::OP_LOAD, 8'd255, 10'd1023, 10'd1023, 32'h7FFF_FFFF);
    send_request(sgcs_pkg::OP_COMPARE, 8'd0, 10'd0, 10'd1023, 32'h0);
    send_request(sgcs_pkg::OP_COMPARE, 8'd255, 10'd1023, 10'd512, 32'hFFFF_FFFF);
    send_request(sgcs_pkg::OP_COMPARE, 8'd0, 10'd0, 10'd0, 32'h0);
    send_request(sgcs_pkg::OP_COMPARE, 8'd0, 10'd2, 10'd0, 32'h8000_0000);
    send_request(sgcs_pkg::OP_COMPARE, 8'd0, 10'd1, 10'd1023, 32'h7FFF_FFFF);
    write_rows(9'd2);
    send_request(sgcs_pkg::OP_LOAD, 8'd1, 10'd0, 10'd1023, 32'd5);
    send_request(sgcs_pkg::OP_LOAD, 8'd1, 10'd2, 10'd0, 32'd5);
    send_request(sgcs_pkg::OP_LOAD, 8'd1, 10'd1023, 10'd0, 32'd9);
    send_request(sgcs_pkg::OP_COMPARE, 8'd0, 10'd0, 10'd2, 32'h0);
    send_request(sgcs_pkg::OP_COMPARE, 8'd0, 10'd1023, 10'd0, 32'h0);
  endtask

  task automatic test_single_row();
    run_random_phase(9'd1, 6, 120);
  endtask

  task automatic test_short_columns();
    run_random_phase(sgcs_pkg::RCFG_W'($urandom_range(2, 8)), 5, 150);
  endtask

  task automatic test_medium_columns();
    run_random_phase(sgcs_pkg::RCFG_W'($urandom_range(9, 40)), 4, 150);
  endtask

  // Full height: widest union, full match, then the over-range row count
  task automatic test_full_columns();
    logic [sgcs_pkg::COL_W-1:0] col;
    write_rows(9'd256);
    for (int r = 0; r < NUM_ROWS; r++) begin
      send_request(sgcs_pkg::OP_LOAD, sgcs_pkg::ROW_W'(r), 10'd0,
                   sgcs_pkg::COL_W'($urandom), r + 1);
      send_request(sgcs_pkg::OP_LOAD, sgcs_pkg::ROW_W'(r), 10'd1023,
                   sgcs_pkg::COL_W'($urandom), 32'h7FFF_FFFF - r);
    end
    send_request(sgcs_pkg::OP_COMPARE, 8'd0, 10'd0, 10'd1023, 32'h0);
    send_request(sgcs_pkg::OP_COMPARE, 8'd0, 10'd1023, 10'd1023, 32'h0);
    send_request(sgcs_pkg::OP_COMPARE, 8'd0, 10'd1023, 10'd0, 32'h0);
    // Rows above the matrix act as the full height; rewrite the two full columns
    write_rows(9'd511);
    for (int n = 0; n < 20; n++) begin
      col = ($urandom_range(0, 1) == 0) ? '0 : sgcs_pkg::COL_W'(NUM_COLS - 1);
      send_request(sgcs_pkg::OP_LOAD, sgcs_pkg::ROW_W'($urandom), col,
                   sgcs_pkg::COL_W'($urandom), pick_value());
      send_request(sgcs_pkg::OP_COMPARE, sgcs_pkg::ROW_W'($urandom), 10'd0, 10'd1023,
                   $urandom);
    end
  endtask

  task automatic test_zero_rows();
    run_random_phase('0, 4, 80);
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_corner_cases();
    test_single_row();
    test_short_columns();
    test_medium_columns();
    test_full_columns();
    test_zero_rows();
    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (pending_scores.size() != 0)
      report_mismatch("results still pending", 0, pending_scores.size());
    if (error_count == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule

// ----- files.f -----
rtl/sgcs_pkg.sv
rtl/sgcs_ram.sv
rtl/sgcs_divider.sv
rtl/signature_column_similarity.sv
verif/signature_column_similarity_test.sv
